@@ hw/rtl/cffs_pkg.sv @@
// Package for the coarse/fine focus search block: field widths, phase and
// fine-scan mode types, scan constants and the fine-position function.
// No dependencies.
package cffs_pkg;

  localparam int POS_W   = 8;
  localparam int SCORE_W = 16;
  localparam int STEP_W  = 8;

  localparam int FOCUS_MAX_DEF   = 255;
  localparam int FINE_POINTS_DEF = 10;

  // Widest fine index the parameter range can need (FINE_POINTS up to 16).
  localparam int FINE_IDX_MAX_W = 5;

  localparam logic [POS_W-1:0] STEP_RESET = 8'd10;

  // Edges that select the fine-scan window and the window bases.
  localparam logic [POS_W-1:0] HIGH_EDGE  = 8'd247;
  localparam logic [POS_W-1:0] LOW_EDGE   = 8'd8;
  localparam logic [9:0]       HIGH_BASE  = 10'd240;
  localparam logic [9:0]       LOW_BASE   = 10'd1;
  localparam logic [9:0]       MID_BELOW  = 10'd6;
  localparam logic [9:0]       MID_ABOVE  = 10'd5;
  localparam logic [FINE_IDX_MAX_W-1:0] MID_SKIP = 5'd6;
  localparam logic [9:0]       POS_SAT    = 10'd255;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_COARSE = 2'd1,
    PH_FINE   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MODE_MID  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_LOW  = 2'd2
  } fine_mode_e;

  // Position of fine point i. Around the middle the centre itself is
  // skipped; the sum saturates at the top of the 8-bit range.
  function automatic logic [POS_W-1:0] fine_point(fine_mode_e mode,
                                                   logic [POS_W-1:0] origin,
                                                   logic [FINE_IDX_MAX_W-1:0] i);
    logic [9:0] p;
    case (mode)
      MODE_HIGH: p = HIGH_BASE + {5'd0, i};
      MODE_LOW:  p = LOW_BASE + {5'd0, i};
      default: begin
        if (i < MID_SKIP) begin
          p = {2'd0, origin} + {5'd0, i} - MID_BELOW;
        end else begin
          p = {2'd0, origin} + {5'd0, i} - MID_ABOVE;
        end
      end
    endcase
    if (p > POS_SAT) begin
      p = POS_SAT;
    end
    return p[POS_W-1:0];
  endfunction

endpackage

@@ hw/rtl/cffs_if.sv @@
// Channel interfaces of the focus search block: request, result and
// configuration write. Depends on cffs_pkg for the field widths.
interface cffs_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [cffs_pkg::SCORE_W-1:0]  sharpness;
  modport source (output valid, output req_type, output sharpness, input ready);
  modport sink   (input valid, input req_type, input sharpness, output ready);
endinterface

interface cffs_res_if;
  logic                          valid;
  logic                          ready;
  logic [cffs_pkg::POS_W-1:0]    focus_value;
  logic                          done_res;
  logic [cffs_pkg::SCORE_W-1:0]  best_score;
  modport source (output valid, output focus_value, output done_res,
                  output best_score, input ready);
  modport sink   (input valid, input focus_value, input done_res,
                  input best_score, output ready);
endinterface

interface cffs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cffs_pkg::STEP_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/coarse_fine_focus_search.sv @@
// Top level of the coarse-to-fine autofocus search sequencer.
// Depends on cffs_pkg and the channel interfaces in cffs_if.sv.
//
//   channel  port    dir  payload                              transfer when
//   request  req_i   in   req_type, sharpness                  valid && ready
//   result   res_o   out  focus_value, done_res, best_score    valid && ready
//   config   cfg_i   in   data (coarse_step)                   valid && ready
//
// Every request produces exactly one result: it waits in the input register,
// then the search state and the result register update together when it
// moves on. One request per cycle is sustained while the result side is
// ready; the state update between the input register and the result
// register is the only loop. Configuration writes are always accepted
// (ready is tied high).
// Reset (rst_ni low, asynchronous) empties both registers, sets the coarse
// step to 10 and clears the search state to idle at position 0.
// A stalled result holds; a new request still enters the input register,
// and the request side stalls only once that register is also full.
module coarse_fine_focus_search #(
  parameter int FOCUS_MAX   = cffs_pkg::FOCUS_MAX_DEF,
  parameter int FINE_POINTS = cffs_pkg::FINE_POINTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cffs_req_if.sink  req_i,
  cffs_res_if.source res_o,
  cffs_cfg_if.sink  cfg_i
);

  localparam int POS_W   = cffs_pkg::POS_W;
  localparam int SCORE_W = cffs_pkg::SCORE_W;
  localparam int IDX_W   = $clog2(FINE_POINTS + 1);
  // Positions are 8 bits wide, so the coarse sweep never passes 255.
  localparam int LIMIT   = (FOCUS_MAX > 255) ? 255 : FOCUS_MAX;

  // Configuration register.
  logic [cffs_pkg::STEP_W-1:0] step_q;

  // Input register.
  logic               in_vld_q;
  logic               req_type_q;
  logic [SCORE_W-1:0] sharp_q;

  // Search state.
  cffs_pkg::phase_e     phase_q, phase_d;
  cffs_pkg::fine_mode_e mode_q, mode_d;
  logic [POS_W-1:0]     cur_q, cur_d;
  logic [POS_W-1:0]     best_pos_q, best_pos_d;
  logic [SCORE_W-1:0]   best_val_q, best_val_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [POS_W-1:0]     origin_q, origin_d;

  // Result register.
  logic               out_vld_q;
  logic [POS_W-1:0]   out_pos_q;
  logic               out_done_q;
  logic [SCORE_W-1:0] out_best_q;
  logic               done_d;

  logic move;
  logic req_ready;

  // Helper values of the update.
  logic [POS_W-1:0]   step_eff;
  logic [POS_W:0]     next_pos;
  logic               beats;
  logic [POS_W-1:0]   cred_pos;
  logic [SCORE_W-1:0] cred_val;
  logic [IDX_W-1:0]   idx_inc;
  cffs_pkg::fine_mode_e new_mode;

  // The head item moves into the result register whenever that register is
  // empty or its contents transfer in this cycle.
  assign move      = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_ready = !in_vld_q || move;
  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid       = out_vld_q;
  assign res_o.focus_value = out_pos_q;
  assign res_o.done_res    = out_done_q;
  assign res_o.best_score  = out_best_q;

  // A score is credited to the last commanded position when it strictly
  // beats the best so far.
  assign beats    = sharp_q > best_val_q;
  assign cred_pos = beats ? cur_q : best_pos_q;
  assign cred_val = beats ? sharp_q : best_val_q;

  // A zero step would stall the sweep, so it counts as one.
  assign step_eff = (step_q == '0) ? {{(POS_W-1){1'b0}}, 1'b1} : step_q;
  assign next_pos = {1'b0, cur_q} + {1'b0, step_eff};
  assign idx_inc  = idx_q + {{(IDX_W-1){1'b0}}, 1'b1};

  // The fine window follows the coarse best: pinned at either end of the
  // range, centred on it elsewhere.
  always_comb begin
    if (cred_pos >= cffs_pkg::HIGH_EDGE) begin
      new_mode = cffs_pkg::MODE_HIGH;
    end else if (cred_pos <= cffs_pkg::LOW_EDGE) begin
      new_mode = cffs_pkg::MODE_LOW;
    end else begin
      new_mode = cffs_pkg::MODE_MID;
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (!req_type_q) begin
      phase_d = cffs_pkg::PH_COARSE;
    end else begin
      case (phase_q)
        cffs_pkg::PH_COARSE: begin
          if (next_pos > (POS_W+1)'(LIMIT)) begin
            phase_d = cffs_pkg::PH_FINE;
          end
        end
        cffs_pkg::PH_FINE: begin
          if (idx_inc >= IDX_W'(FINE_POINTS)) begin
            phase_d = cffs_pkg::PH_DONE;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Datapath and result of the update.
  always_comb begin
    cur_d      = cur_q;
    best_pos_d = best_pos_q;
    best_val_d = best_val_q;
    idx_d      = idx_q;
    origin_d   = origin_q;
    mode_d     = mode_q;
    done_d     = 1'b0;
    if (!req_type_q) begin
      cur_d      = '0;
      best_pos_d = '0;
      best_val_d = '0;
      idx_d      = '0;
    end else begin
      case (phase_q)
        cffs_pkg::PH_COARSE: begin
          best_pos_d = cred_pos;
          best_val_d = cred_val;
          if (next_pos <= (POS_W+1)'(LIMIT)) begin
            cur_d = next_pos[POS_W-1:0];
          end else begin
            origin_d = cred_pos;
            mode_d   = new_mode;
            idx_d    = '0;
            cur_d    = cffs_pkg::fine_point(new_mode, cred_pos, '0);
          end
        end
        cffs_pkg::PH_FINE: begin
          best_pos_d = cred_pos;
          best_val_d = cred_val;
          idx_d      = idx_inc;
          if (idx_inc < IDX_W'(FINE_POINTS)) begin
            cur_d = cffs_pkg::fine_point(mode_q, origin_q,
                                         cffs_pkg::FINE_IDX_MAX_W'(idx_inc));
          end else begin
            cur_d  = cred_pos;
            done_d = 1'b1;
          end
        end
        cffs_pkg::PH_DONE: begin
          cur_d  = best_pos_q;
          done_d = 1'b1;
        end
        default: begin
          // A report while idle is ignored.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= cffs_pkg::STEP_RESET;
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      phase_q    <= cffs_pkg::PH_IDLE;
      mode_q     <= cffs_pkg::MODE_MID;
      cur_q      <= '0;
      best_pos_q <= '0;
      best_val_q <= '0;
      idx_q      <= '0;
      origin_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        step_q <= cfg_i.data;
      end
      if (req_ready) begin
        in_vld_q <= req_i.valid;
      end
      if (move) begin
        out_vld_q  <= 1'b1;
        phase_q    <= phase_d;
        mode_q     <= mode_d;
        cur_q      <= cur_d;
        best_pos_q <= best_pos_d;
        best_val_q <= best_val_d;
        idx_q      <= idx_d;
        origin_q   <= origin_d;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (req_ready && req_i.valid) begin
      req_type_q <= req_i.req_type;
      sharp_q    <= req_i.sharpness;
    end
    if (move) begin
      out_pos_q  <= cur_d;
      out_done_q <= done_d;
      out_best_q <= best_val_d;
    end
  end

  // A result marked done only leaves once the search has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_done_q |-> phase_q == cffs_pkg::PH_DONE)
    else $error("done result while search not finished");

  // The fine counter stays inside the window during the fine sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cffs_pkg::PH_FINE |-> idx_q < IDX_W'(FINE_POINTS))
    else $error("fine index outside the window");

  // A window pinned at the top end only commands positions in that end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cffs_pkg::PH_FINE && mode_q == cffs_pkg::MODE_HIGH
    |-> cur_q >= POS_W'(cffs_pkg::HIGH_BASE))
    else $error("high-end fine position below its base");

  // The request side stalls only while the input register is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready |-> in_vld_q && out_vld_q && !res_o.ready)
    else $error("request stalled without a full pipeline");

endmodule

@@ test/focus_search_tb_pkg.sv @@
// Checking support for the focus search testbench: a tracker class that predicts
// each result of the search sequencer and compares the results that the block sends.
// Depends on cffs_pkg for widths, phase and fine-scan mode types.
package focus_search_tb_pkg;
  import cffs_pkg::*;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_SCORE = 1'b1;

  localparam int POS_TOP        = (FOCUS_MAX_DEF > 255) ? 255 : FOCUS_MAX_DEF;
  localparam int FINE_HIGH_BASE = 240;
  localparam int FINE_LOW_BASE  = 1;
  localparam int FINE_BELOW     = 6;

  typedef struct {
    logic [POS_W-1:0]   focus;
    logic               done;
    logic [SCORE_W-1:0] score;
  } focus_result_t;

  class focus_tracker;
    logic [STEP_W-1:0]  step;
    phase_e             phase;
    fine_mode_e         mode;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   best_pos;
    logic [POS_W-1:0]   origin;
    logic [SCORE_W-1:0] best;
    int unsigned        fine_taken;
    focus_result_t      awaited[$];
    int                 errors;

    function new();
      step       = STEP_RESET;
      phase      = PH_IDLE;
      mode       = MODE_MID;
      pos        = '0;
      best_pos   = '0;
      origin     = '0;
      best       = '0;
      fine_taken = 0;
      errors     = 0;
    endfunction

    function void write_step(logic [STEP_W-1:0] value);
      step = value;
    endfunction

    // Fine window position for point i; the middle window steps over the
    // coarse best itself.
    function logic [POS_W-1:0] fine_target(int unsigned i);
      int p;
      if (mode == MODE_HIGH) begin
        p = FINE_HIGH_BASE + int'(i);
      end else if (mode == MODE_LOW) begin
        p = FINE_LOW_BASE + int'(i);
      end else begin
        p = int'(origin) + int'(i) - FINE_BELOW + ((i >= FINE_BELOW) ? 1 : 0);
      end
      if (p > 255) begin
        p = 255;
      end
      return p[POS_W-1:0];
    endfunction

    function void keep_if_sharper(logic [SCORE_W-1:0] score);
      if (score > best) begin
        best     = score;
        best_pos = pos;
      end
    endfunction

    // Advances the search by one accepted request and queues the result it causes.
    function void note_request(logic req_type, logic [SCORE_W-1:0] score);
      focus_result_t r;
      int next;
      r.done = 1'b0;
      if (req_type == REQ_START) begin
        phase      = PH_COARSE;
        pos        = '0;
        best_pos   = '0;
        best       = '0;
        fine_taken = 0;
      end else begin
        case (phase)
          PH_COARSE: begin
            next = int'(pos) + ((step == '0) ? 1 : int'(step));
            keep_if_sharper(score);
            if (next <= POS_TOP) begin
              pos = next[POS_W-1:0];
            end else begin
              origin = best_pos;
              if (origin >= HIGH_EDGE) begin
                mode = MODE_HIGH;
              end else if (origin <= LOW_EDGE) begin
                mode = MODE_LOW;
              end else begin
                mode = MODE_MID;
              end
              fine_taken = 0;
              phase      = PH_FINE;
              pos        = fine_target(0);
            end
          end
          PH_FINE: begin
            keep_if_sharper(score);
            fine_taken++;
            if (fine_taken < FINE_POINTS_DEF) begin
              pos = fine_target(fine_taken);
            end else begin
              phase  = PH_DONE;
              pos    = best_pos;
              r.done = 1'b1;
            end
          end
          PH_DONE: begin
            pos    = best_pos;
            r.done = 1'b1;
          end
          default: ;
        endcase
      end
      r.focus = pos;
      r.score = best;
      awaited.push_back(r);
    endfunction

    function void check_result(logic [POS_W-1:0] focus, logic done,
                               logic [SCORE_W-1:0] score);
      focus_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: focus_value %0d done_res %0b best_score %0d",
               focus, done, score);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (focus !== want.focus) begin
        $error("focus_value: expected %0d, actual %0d", want.focus, focus);
        errors++;
      end
      if (done !== want.done) begin
        $error("done_res: expected %0b, actual %0b", want.done, done);
        errors++;
      end
      if (score !== want.score) begin
        $error("best_score: expected %0d, actual %0d", want.score, score);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [POS_W-1:0] commanded();
      return pos;
    endfunction

    function bit finished();
      return phase == PH_DONE;
    endfunction
  endclass

endpackage

@@ test/tb_top.sv @@
// Top of the focus search testbench: drives requests and step writes into the
// sequencer, stalls its result channel and checks every result in order.
// Depends on cffs_pkg, the channel interfaces, the DUT and focus_search_tb_pkg.
module tb_top;
  import cffs_pkg::*;
  import focus_search_tb_pkg::*;

  // A correct run never goes long without a transfer, even with the
  // heavier stall setting.
  localparam int STALL_LIMIT   = 2000;
  localparam int SEGMENT_ITEMS = 80;
  localparam int SEGMENTS      = 8;

  typedef enum {SHAPE_PEAK, SHAPE_NOISE, SHAPE_FLAT, SHAPE_RAIL} score_shape_e;

  logic clk_i;
  logic rst_ni;

  cffs_req_if req_ch();
  cffs_res_if res_ch();
  cffs_cfg_if cfg_ch();

  coarse_fine_focus_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  focus_tracker tracker = new();

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  // Shape of the sharpness curve that the current search sees.
  score_shape_e shape;
  int peak;
  int height;
  int slope;
  int flat_level;

  logic [STEP_W-1:0] step_plan [SEGMENTS];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Presents one request and returns at the edge where it is accepted. The
  // valid line is lowered only in idle cycles, never in the step where the
  // next request goes up, so each step sees one assignment to it at most.
  task automatic send_item(logic req_type, logic [SCORE_W-1:0] sharpness);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= req_type;
    req_ch.sharpness <= sharpness;
    do @(posedge clk_i); while (!req_ch.ready);
    tracker.note_request(req_type, sharpness);
    items_sent++;
  endtask

  // Every request yields exactly one result, so an empty expectation queue
  // means the block holds nothing; the extra wait after it covers the input
  // and result registers and would expose any stray result.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_step(logic [STEP_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tracker.write_step(value);
  endtask

  // Sharpness at lens position p for the current search. Peaked curves push
  // the best position around, flat ones exercise the strict comparison, and
  // rail values hit both ends of the score range.
  function automatic logic [SCORE_W-1:0] shaped_score(logic [POS_W-1:0] p);
    int d;
    int v;
    case (shape)
      SHAPE_PEAK: begin
        d = int'(p) - peak;
        if (d < 0) begin
          d = -d;
        end
        v = height - slope * d + int'($urandom_range(0, 63));
        if (v < 0) begin
          v = 0;
        end
        if (v > 65535) begin
          v = 65535;
        end
      end
      SHAPE_NOISE: v = $urandom_range(0, 65535);
      SHAPE_FLAT:  v = flat_level;
      default:     v = $urandom_range(1) ? 65535 : 0;
    endcase
    return v[SCORE_W-1:0];
  endfunction

  // One search from start to done. Now and then the search is restarted
  // midway (at most once, so that slow sweeps still finish), and after done
  // up to two extra reports check that the final position is held.
  task automatic run_search();
    int pick;
    int extra;
    bit restarted;
    pick = $urandom_range(99);
    if (pick < 60) begin
      shape = SHAPE_PEAK;
    end else if (pick < 80) begin
      shape = SHAPE_NOISE;
    end else if (pick < 90) begin
      shape = SHAPE_FLAT;
    end else begin
      shape = SHAPE_RAIL;
    end
    // Peaks near either end of the lens range steer the fine window to the
    // low and high edge cases as often as to the middle.
    pick = $urandom_range(3);
    if (pick == 0) begin
      peak = $urandom_range(0, 8);
    end else if (pick == 1) begin
      peak = $urandom_range(247, 255);
    end else begin
      peak = $urandom_range(0, 255);
    end
    height     = $urandom_range(0, 65535);
    slope      = $urandom_range(1, 600);
    flat_level = $urandom_range(0, 65535);
    restarted  = 1'b0;
    send_item(REQ_START, SCORE_W'($urandom_range(0, 65535)));
    while (!tracker.finished()) begin
      if (!restarted && $urandom_range(99) < 2) begin
        restarted = 1'b1;
        send_item(REQ_START, SCORE_W'($urandom_range(0, 65535)));
      end else begin
        send_item(REQ_SCORE, shaped_score(tracker.commanded()));
      end
    end
    extra = $urandom_range(0, 2);
    repeat (extra) send_item(REQ_SCORE, SCORE_W'($urandom_range(0, 65535)));
  endtask

  // Result side: check each transfer against the oldest expectation and
  // pick the ready level for the next cycle.
  always @(posedge clk_i) begin
    if (res_ch.valid && res_ch.ready) begin
      tracker.check_result(res_ch.focus_value, res_ch.done_res, res_ch.best_score);
    end
    res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: a hung handshake on any channel ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int seg;
    int unsigned seg_start;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_START;
    req_ch.sharpness = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    res_ch.ready     = 1'b0;
    src_idle_pct     = 17;
    sink_idle_pct    = 52;
    items_sent       = 0;
    quiet_cycles     = 0;

    // Step settings per segment: a zero step (swept as one), the smallest and
    // largest steps, the reset value and some arbitrary ones.
    step_plan[0] = 8'd0;
    step_plan[1] = 8'd37;
    step_plan[2] = STEP_W'($urandom_range(2, 254));
    step_plan[3] = 8'd1;
    step_plan[4] = 8'd128;
    step_plan[5] = STEP_W'($urandom_range(2, 254));
    step_plan[6] = STEP_RESET;
    step_plan[7] = 8'd255;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A report before any search has started is ignored and echoes position 0.
    send_item(REQ_SCORE, 16'hFFFF);
    drain();

    // The largest step visits only 0 and 255. A winner at 255 selects the
    // high-end fine window 240..249; there a tie must not move the best
    // position while a strictly higher score must.
    write_step(8'd255);
    send_item(REQ_START, 16'h5A5A);
    send_item(REQ_SCORE, 16'h0001);
    send_item(REQ_SCORE, 16'hFFFE);
    send_item(REQ_SCORE, 16'hFFFE);
    send_item(REQ_SCORE, 16'hFFFF);
    repeat (8) send_item(REQ_SCORE, 16'h0000);
    // Once done, further reports repeat the chosen position.
    send_item(REQ_SCORE, 16'hFFFF);

    // A winner at 0 selects the low-end window 1..10. A start during the
    // fine sweep throws the search back to position 0.
    send_item(REQ_START, 16'h0000);
    send_item(REQ_SCORE, 16'hFFFF);
    send_item(REQ_SCORE, 16'h8000);
    repeat (3) send_item(REQ_SCORE, 16'h7FFF);
    send_item(REQ_START, 16'hFFFF);
    send_item(REQ_SCORE, 16'h1234);

    // Random searches. The first three segments stall the result side more
    // than the request side, the next three the other way round, and the
    // last two run without idle cycles.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 3) begin
        src_idle_pct  = 52;
        sink_idle_pct = 17;
      end else if (seg == 6) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      drain();
      write_step(step_plan[seg]);
      seg_start = items_sent;
      while (items_sent - seg_start < SEGMENT_ITEMS) run_search();
    end

    drain();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ coarse_fine_focus_search.f @@
hw/rtl/cffs_pkg.sv
hw/rtl/cffs_if.sv
hw/rtl/coarse_fine_focus_search.sv
test/focus_search_tb_pkg.sv
test/tb_top.sv
